// ===== sv/ordered_array_store_core_assert.svh =====
// ----------------------------------------------------------------------------
// ordered_array_store_core_assert.svh
// Assertion macros for the ordered array store; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_STORE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_STORE_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define OAS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oas assertion failed");
// next-cycle implication
`define OAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oas assertion failed");
`else
`define OAS_ASSERT_SAME(label, clk, rst, ante, cons)
`define OAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/oas_pkg.sv =====
// ----------------------------------------------------------------------------
// oas_pkg
// Shared sizes, operation codes and cell source codes of the array store.
// ----------------------------------------------------------------------------
package oas_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int CAP_W  = 5;
   localparam int SRC_W  = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
   localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
   localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
   localparam logic [OP_W-1:0] OP_READ    = 3'd5;

   // where a cell takes its next word from
   localparam logic [SRC_W-1:0] SRC_HOLD  = 2'd0;
   localparam logic [SRC_W-1:0] SRC_VALUE = 2'd1;
   localparam logic [SRC_W-1:0] SRC_LEFT  = 2'd2;
   localparam logic [SRC_W-1:0] SRC_RIGHT = 2'd3;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [SRC_W-1:0]         src_type;
   typedef logic [OP_W-1:0]          op_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [CAP_W-1:0]         cap_type;

endpackage

// ===== sv/oas_if.sv =====
// ----------------------------------------------------------------------------
// oas_if
// Valid/ready channels of the array store: request, response and CSR write.
// ----------------------------------------------------------------------------
interface oas_req_if;
   logic               valid;
   logic               ready;
   oas_pkg::op_type    op;
   oas_pkg::idx_type   index;
   oas_pkg::data_type  value;

   modport source (output valid, op, index, value, input ready);
   modport sink   (input valid, op, index, value, output ready);
endinterface

interface oas_rsp_if;
   logic               valid;
   logic               ready;
   logic               ok;
   oas_pkg::data_type  read_value;
   oas_pkg::cnt_type   count;
   logic               full_res;
   logic               empty_res;

   modport source (output valid, ok, read_value, count, full_res, empty_res,
                   input ready);
   modport sink   (input valid, ok, read_value, count, full_res, empty_res,
                   output ready);
endinterface

interface oas_csr_if;
   logic               valid;
   logic               ready;
   oas_pkg::cap_type   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== sv/oas_cell.sv =====
// ----------------------------------------------------------------------------
// oas_cell
// One entry of the list: holds a word or takes it from a neighbor or the bus.
// ----------------------------------------------------------------------------
module oas_cell (
   input  logic               clock,
   input  oas_pkg::src_type   src,
   input  oas_pkg::data_type  left_data,
   input  oas_pkg::data_type  right_data,
   input  oas_pkg::data_type  wr_data,
   output oas_pkg::data_type  data
);

   oas_pkg::data_type data_ff;
   oas_pkg::data_type data_in;

   // pick the next word
   always_comb begin
      unique case (src)
         oas_pkg::SRC_VALUE: data_in = wr_data;
         oas_pkg::SRC_LEFT:  data_in = left_data;
         oas_pkg::SRC_RIGHT: data_in = right_data;
         default:            data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== sv/oas_ctrl.sv =====
// ----------------------------------------------------------------------------
// oas_ctrl
// Decodes request beats into per-cell moves, tracks the count, runs the
// reverse rounds and registers the response beat.
// ----------------------------------------------------------------------------
`include "ordered_array_store_core_assert.svh"

module oas_ctrl (
   input  logic               clock,
   input  logic               reset,
   oas_req_if.sink            req_ch,
   oas_rsp_if.source          rsp_ch,
   oas_csr_if.sink            csr_ch,
   input  oas_pkg::data_type  cell_data [oas_pkg::DEPTH],
   output oas_pkg::src_type   cell_src  [oas_pkg::DEPTH]
);

   oas_pkg::cap_type   cap_ff;
   oas_pkg::cnt_type   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   oas_pkg::idx_type   rnd_ff, rnd_in;
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   oas_pkg::data_type  rsp_rd_ff;
   oas_pkg::cnt_type   rsp_cnt_ff;
   logic               rsp_full_ff;
   logic               rsp_empty_ff;

   oas_pkg::cnt_type   lim;
   oas_pkg::cnt_type   idx_ext;
   logic               req_acc;
   logic               room;
   logic               ok;
   oas_pkg::data_type  rd;
   logic               rev_start;
   logic               swap_en;
   logic               parity;

   // CSR write: always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= oas_pkg::CAP_RESET;
      end else if (csr_ch.valid) begin
         cap_ff <= csr_ch.data;
      end
   end

   // limit saturates at the built depth
   assign lim = (cap_ff > oas_pkg::CAP_W'(oas_pkg::DEPTH)) ?
                oas_pkg::CNT_W'(oas_pkg::DEPTH) : oas_pkg::CNT_W'(cap_ff);
   assign idx_ext = oas_pkg::CNT_W'(req_ch.index);
   assign room    = (cnt_ff < lim) && (cnt_ff < oas_pkg::CNT_W'(oas_pkg::DEPTH));

   // take a request only when no reverse runs and the response slot frees
   assign req_ch.ready = !busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_acc      = req_ch.valid && req_ch.ready;

   // decide the operation outcome
   always_comb begin
      ok     = 1'b0;
      rd     = '0;
      cnt_in = cnt_ff;
      unique case (req_ch.op)
         oas_pkg::OP_APPEND: begin
            ok = room;
            if (room) cnt_in = cnt_ff + 1'b1;
         end
         oas_pkg::OP_INSERT: begin
            ok = room && (idx_ext <= cnt_ff);
            if (ok) cnt_in = cnt_ff + 1'b1;
         end
         oas_pkg::OP_REMOVE: begin
            ok = idx_ext < cnt_ff;
            if (ok) cnt_in = cnt_ff - 1'b1;
         end
         oas_pkg::OP_REPLACE: begin
            ok = idx_ext < cnt_ff;
         end
         oas_pkg::OP_REVERSE: begin
            ok = cnt_ff != '0;
         end
         oas_pkg::OP_READ: begin
            ok = idx_ext < cnt_ff;
            if (ok) rd = cell_data[req_ch.index];
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // reverse runs count odd-even swap rounds, the first one at accept
   assign rev_start = req_acc && (req_ch.op == oas_pkg::OP_REVERSE) &&
                      (cnt_ff >= oas_pkg::CNT_W'(2));
   assign swap_en   = rev_start || busy_ff;
   assign parity    = busy_ff ? rnd_ff[0] : 1'b0;

   // per-cell source select
   always_comb begin
      oas_pkg::cnt_type pos;
      for (int i = 0; i < oas_pkg::DEPTH; i++) begin
         pos         = oas_pkg::CNT_W'(i);
         cell_src[i] = oas_pkg::SRC_HOLD;
         if (swap_en) begin
            if ((pos[0] == parity) && (pos + 1'b1 < cnt_ff)) begin
               cell_src[i] = oas_pkg::SRC_RIGHT;
            end else if ((pos[0] != parity) && (pos != '0) && (pos < cnt_ff)) begin
               cell_src[i] = oas_pkg::SRC_LEFT;
            end
         end else if (req_acc && ok) begin
            case (req_ch.op)
               oas_pkg::OP_APPEND: begin
                  if (pos == cnt_ff) cell_src[i] = oas_pkg::SRC_VALUE;
               end
               oas_pkg::OP_INSERT: begin
                  if (pos == idx_ext) cell_src[i] = oas_pkg::SRC_VALUE;
                  else if ((pos > idx_ext) && (pos <= cnt_ff))
                     cell_src[i] = oas_pkg::SRC_LEFT;
               end
               oas_pkg::OP_REMOVE: begin
                  if ((pos >= idx_ext) && (pos + 1'b1 < cnt_ff))
                     cell_src[i] = oas_pkg::SRC_RIGHT;
               end
               oas_pkg::OP_REPLACE: begin
                  if (pos == idx_ext) cell_src[i] = oas_pkg::SRC_VALUE;
               end
               default: begin
                  cell_src[i] = oas_pkg::SRC_HOLD;
               end
            endcase
         end
      end
   end

   // advance the reverse round counter
   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      if (rev_start) begin
         busy_in = 1'b1;
         rnd_in  = oas_pkg::IDX_W'(1);
      end else if (busy_ff) begin
         if (oas_pkg::CNT_W'(rnd_ff) == cnt_ff - 1'b1) begin
            busy_in = 1'b0;
         end else begin
            rnd_in = rnd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         busy_ff      <= 1'b0;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
         if (req_acc) begin
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_ok_ff    <= ok;
         rsp_rd_ff    <= rd;
         rsp_cnt_ff   <= cnt_in;
         rsp_full_ff  <= cnt_in >= lim;
         rsp_empty_ff <= cnt_in == '0;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.ok         = rsp_ok_ff;
   assign rsp_ch.read_value = rsp_rd_ff;
   assign rsp_ch.count      = rsp_cnt_ff;
   assign rsp_ch.full_res   = rsp_full_ff;
   assign rsp_ch.empty_res  = rsp_empty_ff;

   `OAS_ASSERT_SAME(a_busy_blocks, clock, reset, busy_ff, !req_ch.ready)
   `OAS_ASSERT_SAME(a_busy_needs_pair, clock, reset, busy_ff,
                    cnt_ff >= oas_pkg::CNT_W'(2))
   `OAS_ASSERT_NEXT(a_append_grows, clock, reset,
                    req_acc && (req_ch.op == oas_pkg::OP_APPEND) && ok,
                    cnt_ff == $past(cnt_ff) + 1'b1)
   `OAS_ASSERT_NEXT(a_beat_answers, clock, reset, req_acc, rsp_valid_ff)

endmodule

// ===== sv/ordered_array_store_core.sv =====
// ----------------------------------------------------------------------------
// ordered_array_store_core
// Ordered list of signed words kept in a chain of neighbor-linked cells.
// ----------------------------------------------------------------------------
// Append, insert, remove, replace and read each complete in the cycle the
// request beat is taken, and the response beat appears from a register in
// the next cycle; a new request can be taken every cycle while the response
// is drained. Reverse runs one odd-even swap round per cycle between
// neighboring cells, count rounds in all, so after a reverse of count >= 2
// entries the request channel holds ready low until the last round. Each
// request gives exactly one response beat. The capacity limit taken from the
// CSR saturates at the built depth; the CSR is written when its valid is high.
module ordered_array_store_core (
   input  logic       clock,
   input  logic       reset,
   oas_req_if.sink    req_ch,
   oas_rsp_if.source  rsp_ch,
   oas_csr_if.sink    csr_ch
);

   oas_pkg::data_type cell_data [oas_pkg::DEPTH];
   oas_pkg::src_type  cell_src  [oas_pkg::DEPTH];

   oas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_ch    (csr_ch),
      .cell_data (cell_data),
      .cell_src  (cell_src)
   );

   // chain the cells; the ends see zero
   for (genvar i = 0; i < oas_pkg::DEPTH; i++) begin : g_cell
      oas_pkg::data_type left_w;
      oas_pkg::data_type right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end

      if (i == oas_pkg::DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end

      oas_cell u_cell (
         .clock      (clock),
         .src        (cell_src[i]),
         .left_data  (left_w),
         .right_data (right_w),
         .wr_data    (req_ch.value),
         .data       (cell_data[i])
      );
   end

endmodule
